>>> rtl/i2cs_pkg.sv
// ----------------------------------------------------------------------------
// i2cs_pkg
// Shared types and constants for the i2c bus register snooper.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cs_pkg;

  // bits in one bus byte and in a device address
  localparam int BYTE_BITS = 8;
  localparam int ADDR_BITS = 7;

  // line event codes
  typedef enum logic [1:0] {
    EV_SCL_RISE   = 2'd0,
    EV_SDA_CHANGE = 2'd1,
    EV_READBACK   = 2'd2
  } event_kind_t;

  // result word codes
  typedef enum logic [1:0] {
    RK_ADDR_ACK = 2'd0,
    RK_POINTER  = 2'd1,
    RK_CAPTURE  = 2'd2,
    RK_READBACK = 2'd3
  } result_kind_t;

  // result produced by the tracker for one event
  typedef struct packed {
    logic                 emit;
    result_kind_t         kind;
    logic [ADDR_BITS-1:0] address;
    logic [BYTE_BITS-1:0] index;
    logic [BYTE_BITS-1:0] data;
    logic                 writing;
    logic                 from_image;
  } track_res_t;

  // image store request
  typedef struct packed {
    logic                 we;
    logic [BYTE_BITS-1:0] addr;
    logic [BYTE_BITS-1:0] data;
  } store_req_t;

endpackage

`default_nettype wire

>>> rtl/i2cs_tracker.sv
// ----------------------------------------------------------------------------
// i2cs_tracker
// Bus protocol tracker: follows start, stop, bit and acknowledge events and
// decides the result word and image store for each accepted event.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cs_tracker (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [1:0]            event_kind,
  input  wire logic                  sda_level,
  input  wire logic                  scl_level,
  input  wire logic [7:0]            readback_index,
  output i2cs_pkg::track_res_t       res,
  output i2cs_pkg::store_req_t       store
);
  import i2cs_pkg::*;

  logic                 bus_idle, bus_idle_next;
  logic [3:0]           bit_count, bit_count_next;
  logic [1:0]           byte_count, byte_count_next;
  logic [BYTE_BITS-1:0] shift_byte, shift_byte_next;
  logic                 write_flag, write_flag_next;
  logic [ADDR_BITS-1:0] latched_address, latched_address_next;
  logic [BYTE_BITS-1:0] register_pointer, register_pointer_next;
  logic                 ack;

  // next state, result and store request
  always_comb begin
    bus_idle_next         = bus_idle;
    bit_count_next        = bit_count;
    byte_count_next       = byte_count;
    shift_byte_next       = shift_byte;
    write_flag_next       = write_flag;
    latched_address_next  = latched_address;
    register_pointer_next = register_pointer;
    ack                   = !sda_level;
    res                   = '0;
    store                 = '0;
    case (event_kind)
      EV_SCL_RISE: begin
        if (!bus_idle) begin
          if (bit_count >= 4'(BYTE_BITS)) begin
            // acknowledge slot
            if (byte_count == 2'd0) begin
              if (ack) begin
                latched_address_next = shift_byte[ADDR_BITS-1:0];
                res.emit  = 1'b1;
                res.kind  = RK_ADDR_ACK;
                res.index = register_pointer;
                res.data  = {1'b0, shift_byte[ADDR_BITS-1:0]};
              end
            end else if (byte_count == 2'd1 && write_flag && ack) begin
              register_pointer_next = shift_byte;
              res.emit  = 1'b1;
              res.kind  = RK_POINTER;
              res.index = shift_byte;
              res.data  = shift_byte;
            end else if (ack) begin
              store.we              = 1'b1;
              store.addr            = register_pointer;
              store.data            = shift_byte;
              register_pointer_next = register_pointer + 8'd1;
              res.emit  = 1'b1;
              res.kind  = RK_CAPTURE;
              res.index = register_pointer;
              res.data  = shift_byte;
            end
            if (byte_count < 2'd2) begin
              byte_count_next = byte_count + 2'd1;
            end
            shift_byte_next = '0;
            bit_count_next  = '0;
          end else if (bit_count == 4'(BYTE_BITS - 1) && byte_count == 2'd0) begin
            // read/write flag of the address byte
            write_flag_next = !sda_level;
            bit_count_next  = bit_count + 4'd1;
          end else begin
            shift_byte_next = {shift_byte[BYTE_BITS-2:0], sda_level};
            bit_count_next  = bit_count + 4'd1;
          end
        end
      end
      EV_SDA_CHANGE: begin
        if (scl_level) begin
          if (sda_level) begin
            // stop
            bus_idle_next = 1'b1;
          end else if (bus_idle) begin
            // start; repeated start while busy is ignored
            bit_count_next        = '0;
            byte_count_next       = '0;
            shift_byte_next       = '0;
            register_pointer_next = '0;
            bus_idle_next         = 1'b0;
          end
        end
      end
      EV_READBACK: begin
        res.emit       = 1'b1;
        res.kind       = RK_READBACK;
        res.index      = readback_index;
        res.from_image = 1'b1;
      end
      default: begin
      end
    endcase
    res.address = latched_address_next;
    res.writing = write_flag;
  end

  // tracker state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_idle         <= 1'b1;
      bit_count        <= '0;
      byte_count       <= '0;
      shift_byte       <= '0;
      write_flag       <= 1'b1;
      latched_address  <= '0;
      register_pointer <= '0;
    end else if (step) begin
      bus_idle         <= bus_idle_next;
      bit_count        <= bit_count_next;
      byte_count       <= byte_count_next;
      shift_byte       <= shift_byte_next;
      write_flag       <= write_flag_next;
      latched_address  <= latched_address_next;
      register_pointer <= register_pointer_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/i2c_bus_register_snooper.sv
// ----------------------------------------------------------------------------
// i2c_bus_register_snooper
// Follows an i2c bus from sampled line events and mirrors the acknowledged data
// bytes of write and read transfers into a register image held in a synchronous memory.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_ready | event_kind sda_level scl_level readback_index
//  out     | out_valid/out_ready | result_kind target_address register_index
//          |                     | data_byte master_writing
//
//  One event word is taken every cycle while in_ready is high; its result
//  word appears in the output register in the cycle after, with read-back
//  data straight from the image memory's registered read port.
//  Reset clears tracker state and one valid bit per image entry at once, so
//  the image reads as zeros with no clearing pass.
//  A stalled output holds its word; in_ready stays high while that word is
//  being taken in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bus_register_snooper #(
  parameter int IMAGE_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] event_kind,
  input  wire logic       sda_level,
  input  wire logic       scl_level,
  input  wire logic [7:0] readback_index,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      result_kind,
  output logic [6:0]      target_address,
  output logic [7:0]      register_index,
  output logic [7:0]      data_byte,
  output logic            master_writing
);
  import i2cs_pkg::*;

  localparam int AW = $clog2(IMAGE_DEPTH);

  logic                   accept;
  track_res_t             res;
  store_req_t             store;
  logic                   rd_in_range;
  logic                   wr_in_range;

  logic [BYTE_BITS-1:0]   image [IMAGE_DEPTH];
  logic [IMAGE_DEPTH-1:0] image_valid;
  logic [BYTE_BITS-1:0]   rd_q;
  logic                   rd_ok;

  logic                   out_from_image;
  logic [1:0]             out_kind;
  logic [ADDR_BITS-1:0]   out_address;
  logic [BYTE_BITS-1:0]   out_index;
  logic [BYTE_BITS-1:0]   out_data;
  logic                   out_writing;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // protocol tracker
  i2cs_tracker u_tracker (
    .clk            (clk),
    .rst            (rst),
    .step           (accept),
    .event_kind     (event_kind),
    .sda_level      (sda_level),
    .scl_level      (scl_level),
    .readback_index (readback_index),
    .res            (res),
    .store          (store)
  );

  assign rd_in_range = {1'b0, readback_index} < 9'(IMAGE_DEPTH);
  assign wr_in_range = {1'b0, store.addr} < 9'(IMAGE_DEPTH);

  // image memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (accept && store.we && wr_in_range) begin
      image[store.addr[AW-1:0]] <= store.data;
    end
    if (accept && res.from_image) begin
      rd_q  <= image[readback_index[AW-1:0]];
      rd_ok <= rd_in_range && image_valid[readback_index[AW-1:0]];
    end
  end

  // per-entry written marks, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      image_valid <= '0;
    end else if (accept && store.we && wr_in_range) begin
      image_valid[store.addr[AW-1:0]] <= 1'b1;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_from_image <= res.from_image;
      out_kind       <= res.kind;
      out_address    <= res.address;
      out_index      <= res.index;
      out_data       <= res.data;
      out_writing    <= res.writing;
    end
  end

  assign result_kind    = out_kind;
  assign target_address = out_address;
  assign register_index = out_index;
  assign data_byte      = out_from_image ? (rd_ok ? rd_q : '0) : out_data;
  assign master_writing = out_writing;

endmodule

`default_nettype wire

>>> rtl/i2cs_checker.sv
// ----------------------------------------------------------------------------
// i2cs_checker
// Port-level checks for the i2c bus register snooper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] event_kind,
  input wire logic [7:0] readback_index,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] result_kind,
  input wire logic [7:0] register_index,
  input wire logic [7:0] data_byte,
  input wire logic       master_writing
);
  import i2cs_pkg::*;

  // stalled result word stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(result_kind) && $stable(register_index)
      && $stable(data_byte))
    else $error("output payload changed while stalled");

  // a read-back request answers in the next cycle with its own index
  a_readback: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && event_kind == EV_READBACK |=>
      out_valid && result_kind == RK_READBACK && register_index == $past(readback_index))
    else $error("read-back result missing or wrong index");

  // sda line changes never produce a word
  a_sda_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && event_kind == EV_SDA_CHANGE |=> !out_valid)
    else $error("word produced by sda change");

  // pointer set only happens in a master write
  a_pointer_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RK_POINTER |-> master_writing)
    else $error("pointer set during a read transfer");

endmodule

bind i2c_bus_register_snooper i2cs_checker u_i2cs_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .event_kind     (event_kind),
  .readback_index (readback_index),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .result_kind    (result_kind),
  .register_index (register_index),
  .data_byte      (data_byte),
  .master_writing (master_writing)
);

`default_nettype wire

>>> dv/i2c_bus_register_snooper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bus_register_snooper_tb
// Drives sampled i2c line events into the snooper: directed corner cases,
// then random write and read transfers mixed with noise and cut-off bytes.
// A local bus tracker predicts every result word, and a monitor checks each
// one field by field. Both channels idle at random; the receiver also holds
// off once for a long stretch so that the input side backs up.
// ----------------------------------------------------------------------------

module i2c_bus_register_snooper_tb;
  import i2cs_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int ITEM_TARGET    = 1150;
  localparam int HOLDOFF_AFTER  = 40;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int DRAIN_CYCLES   = 10;
  localparam int MAX_REPORTS    = 40;

  // event code the block leaves undefined
  localparam logic [1:0] EV_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]           kind;
    logic                 sda;
    logic                 scl;
    logic [BYTE_BITS-1:0] index;
  } bus_event_t;

  typedef struct packed {
    result_kind_t         kind;
    logic [ADDR_BITS-1:0] address;
    logic [BYTE_BITS-1:0] index;
    logic [BYTE_BITS-1:0] data;
    logic                 writing;
  } snoop_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] event_kind = EV_SCL_RISE;
  logic       sda_level = 1'b1;
  logic       scl_level = 1'b1;
  logic [7:0] readback_index = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] result_kind;
  logic [6:0] target_address;
  logic [7:0] register_index;
  logic [7:0] data_byte;
  logic       master_writing;

  i2c_bus_register_snooper DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .event_kind     (event_kind),
    .sda_level      (sda_level),
    .scl_level      (scl_level),
    .readback_index (readback_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .target_address (target_address),
    .register_index (register_index),
    .data_byte      (data_byte),
    .master_writing (master_writing)
  );

  always #5 clk = ~clk;

  // stimulus and expected words
  bus_event_t  bus_events[$];
  snoop_word_t awaited_words[$];
  int          events_queued = 0;
  int          events_accepted = 0;
  int          words_checked = 0;
  int          error_count = 0;
  int          kind_seen[4] = '{0, 0, 0, 0};
  int          cycle_count = 0;

  // bus tracker state
  logic                 line_idle;
  logic [3:0]           bit_cnt;
  logic [1:0]           byte_cnt;
  logic [BYTE_BITS-1:0] shifter;
  logic                 writing;
  logic [ADDR_BITS-1:0] dev_addr;
  logic [BYTE_BITS-1:0] reg_ptr;
  logic [BYTE_BITS-1:0] image [256];

  // idling control
  int   send_gap = 0;
  bit   send_steady = 1'b0;
  int   recv_stall = 0;
  bit   recv_steady = 1'b0;
  int   holdoff_left = 0;
  bit   holdoff_done = 1'b0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  task automatic expect_word(input result_kind_t kind, input logic [7:0] index,
                             input logic [7:0] data);
    awaited_words.push_back('{kind, dev_addr, index, data, writing});
  endtask

  task automatic track_bus_event(input logic [1:0] kind, input logic sda,
                                 input logic scl, input logic [7:0] index);
    case (kind)
      EV_SCL_RISE: begin
        if (!line_idle) begin
          if (bit_cnt >= BYTE_BITS) begin
            // acknowledge slot, low sda means acked
            if (byte_cnt == 2'd0) begin
              if (!sda) begin
                dev_addr = shifter[ADDR_BITS-1:0];
                expect_word(RK_ADDR_ACK, reg_ptr, {1'b0, dev_addr});
              end
            end else if (byte_cnt == 2'd1 && writing && !sda) begin
              reg_ptr = shifter;
              expect_word(RK_POINTER, reg_ptr, reg_ptr);
            end else if (!sda) begin
              // image covers the full 8-bit index range
              image[reg_ptr] = shifter;
              expect_word(RK_CAPTURE, reg_ptr, shifter);
              reg_ptr = reg_ptr + 8'd1;
            end
            if (byte_cnt < 2'd2) byte_cnt = byte_cnt + 2'd1;
            shifter = '0;
            bit_cnt = '0;
          end else if (bit_cnt == ADDR_BITS && byte_cnt == 2'd0) begin
            // read/write flag, low means master writes
            writing = !sda;
            bit_cnt = bit_cnt + 4'd1;
          end else begin
            shifter = {shifter[BYTE_BITS-2:0], sda};
            bit_cnt = bit_cnt + 4'd1;
          end
        end
      end
      EV_SDA_CHANGE: begin
        if (scl) begin
          if (sda) begin
            line_idle = 1'b1;
          end else if (line_idle) begin
            bit_cnt   = '0;
            byte_cnt  = '0;
            shifter   = '0;
            reg_ptr   = '0;
            line_idle = 1'b0;
          end
        end
      end
      EV_READBACK: expect_word(RK_READBACK, index, image[index]);
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch at word %0d on %s: got %h, expected %h",
               words_checked, field, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic push_event(input logic [1:0] kind, input logic sda, input logic scl,
                            input logic [7:0] index);
    bus_events.push_back('{kind, sda, scl, index});
    events_queued++;
  endtask

  task automatic scl_rise(input logic sda);
    push_event(EV_SCL_RISE, sda, 1'($urandom), 8'($urandom));
  endtask

  task automatic bus_start();
    push_event(EV_SDA_CHANGE, 1'b0, 1'b1, 8'($urandom));
  endtask

  task automatic bus_stop();
    push_event(EV_SDA_CHANGE, 1'b1, 1'b1, 8'($urandom));
  endtask

  task automatic read_back(input logic [7:0] index);
    push_event(EV_READBACK, 1'($urandom), 1'($urandom), index);
  endtask

  // msb first, then the acknowledge slot
  task automatic send_byte(input logic [7:0] value, input logic acked);
    for (int i = BYTE_BITS - 1; i >= 0; i--) scl_rise(value[i]);
    scl_rise(!acked);
  endtask

  function automatic logic [6:0] pick_address();
    case ($urandom_range(0, 7))
      0:       return 7'h00;
      1:       return 7'h7F;
      default: return 7'($urandom);
    endcase
  endfunction

  // favor the low entries that read transfers fill and the top for wrap
  function automatic logic [7:0] pick_index();
    case ($urandom_range(0, 3))
      0, 1:    return 8'($urandom_range(0, 15));
      2:       return 8'($urandom_range(240, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------

  initial begin : run_control
    int start_count;
    int n;
    logic acked;

    // corner cases: empty image at both ends, ignored events, top pointer
    read_back(8'h00);
    read_back(8'hFF);
    push_event(EV_SCL_RISE, 1'b1, 1'b1, 8'h00);
    push_event(EV_SDA_CHANGE, 1'b0, 1'b0, 8'h00);
    bus_stop();
    push_event(EV_UNUSED, 1'b1, 1'b1, 8'hFF);
    bus_start();
    send_byte({7'h7F, 1'b0}, 1'b1);
    bus_start();
    send_byte(8'hFF, 1'b1);
    bus_stop();

    // random traffic, mostly well-formed transfers
    start_count = events_queued;
    while (events_queued - start_count < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          bus_start();
          send_byte({pick_address(), 1'b0}, $urandom_range(0, 7) != 0);
          send_byte(pick_index(), $urandom_range(0, 7) != 0);
          repeat ($urandom_range(0, 5)) send_byte(8'($urandom), $urandom_range(0, 9) != 0);
          if ($urandom_range(0, 7) == 0) bus_start();
          bus_stop();
        end
        4, 5: begin
          bus_start();
          send_byte({pick_address(), 1'b1}, $urandom_range(0, 7) != 0);
          n = $urandom_range(1, 4);
          for (int k = 0; k < n; k++) begin
            acked = (k < n - 1) ? ($urandom_range(0, 4) != 0) : 1'($urandom);
            send_byte(8'($urandom), acked);
          end
          bus_stop();
        end
        6, 7: begin
          repeat ($urandom_range(1, 4)) read_back(pick_index());
        end
        8: begin
          repeat ($urandom_range(1, 6))
            push_event(2'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
        end
        default: begin
          // transfer cut off inside the address byte
          bus_start();
          repeat ($urandom_range(1, BYTE_BITS)) scl_rise(1'($urandom));
          bus_stop();
        end
      endcase
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (bus_events.size() > 0 || in_valid) @(posedge clk);
    while (awaited_words.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d bus events and %0d result words", events_accepted,
             words_checked);
    $display("words by kind: address %0d, pointer %0d, capture %0d, read-back %0d",
             kind_seen[RK_ADDR_ACK], kind_seen[RK_POINTER], kind_seen[RK_CAPTURE],
             kind_seen[RK_READBACK]);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // timeout
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // input driver
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : driver
    bus_event_t e;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (bus_events.size() > 0) begin
        e = bus_events.pop_front();
        event_kind     <= e.kind;
        sda_level      <= e.sda;
        scl_level      <= e.scl;
        readback_index <= e.index;
        in_valid       <= 1'b1;
        // alternate between idling and back-to-back stretches
        if ($urandom_range(0, 49) == 0) send_steady = !send_steady;
        send_gap <= send_steady ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output receiver
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : receiver
    int s;
    if (rst) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if ($urandom_range(0, 49) == 0) recv_steady = !recv_steady;
        s = recv_steady ? 0 : $urandom_range(0, 4);
      end else if (recv_stall > 0) begin
        s = recv_stall - 1;
      end else begin
        s = 0;
      end
      recv_stall <= s;
      out_ready  <= (s == 0) && (holdoff_left == 0);
    end
  end

  // one long hold-off so the block backs up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (!holdoff_done && words_checked >= HOLDOFF_AFTER) begin
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_done <= 1'b1;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check result words, then track accepted event words
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : monitor
    snoop_word_t w;
    if (rst) begin
      line_idle = 1'b1;
      bit_cnt   = '0;
      byte_cnt  = '0;
      shifter   = '0;
      writing   = 1'b1;
      dev_addr  = '0;
      reg_ptr   = '0;
      for (int i = 0; i < 256; i++) image[i] = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          report_mismatch("word with nothing awaited", {6'b0, result_kind}, 8'h00);
        end else begin
          w = awaited_words.pop_front();
          if (result_kind !== w.kind)
            report_mismatch("result_kind", {6'b0, result_kind}, {6'b0, w.kind});
          if (target_address !== w.address)
            report_mismatch("target_address", {1'b0, target_address}, {1'b0, w.address});
          if (register_index !== w.index)
            report_mismatch("register_index", register_index, w.index);
          if (data_byte !== w.data)
            report_mismatch("data_byte", data_byte, w.data);
          if (master_writing !== w.writing)
            report_mismatch("master_writing", {7'b0, master_writing}, {7'b0, w.writing});
          kind_seen[w.kind]++;
        end
        words_checked++;
      end
      if (in_valid && in_ready) begin
        track_bus_event(event_kind, sda_level, scl_level, readback_index);
        events_accepted++;
      end
    end
  end

endmodule
